// File: hdl/assert_macros.svh
// assertion macros for the port-level checker, hdl/rc4ms_checker.sv
// no dependencies; include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, off while reset is high
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

// same-cycle implication that also holds through reset
`define ASSERT_ALW(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("%m: check failed");

`endif

// File: hdl/rc4ms_pkg.sv
// shared types and constants for the multi-stream rc4 keystream block
// no dependencies
package rc4ms_pkg;

  localparam int BYTE_W      = 8;
  localparam int STREAM_W    = 3;
  localparam int S_TDATA_W   = 24;
  localparam int S_TUSER_W   = 3;
  localparam int M_TDATA_W   = 8;
  localparam int M_TUSER_W   = 3;

  // item kinds
  typedef enum logic [1:0] {
    KIND_PERM = 2'd0,
    KIND_IJ   = 2'd1,
    KIND_ROT  = 2'd2,
    KIND_DATA = 2'd3
  } kind_t;

  // phases of one keystream step
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RD_B = 2'd1,
    PH_RD_T = 2'd2,
    PH_WR_B = 2'd3
  } phase_t;

  // one input request as handed to the engine
  typedef struct packed {
    kind_t                kind;
    logic [STREAM_W-1:0]  stream;
    logic [BYTE_W-1:0]    index;
    logic [BYTE_W-1:0]    value;
    logic                 start_block;
  } req_t;

endpackage

// File: hdl/rc4_multi_stream_keystream.sv
// top level of the multi-stream rc4 keystream generator
// depends on rc4ms_pkg, rc4ms_perm_mem, rc4ms_engine
//
//   channel  | direction | handshake          | carries
//   s_*      | in        | s_tvalid/s_tready  | loads and data bytes
//   m_*      | out       | m_tvalid/m_tready  | one result per data byte
//
// a data byte occupies the engine through PH_RD_B, PH_RD_T and PH_WR_B: the single read port of the
// permutation store serves s[i], s[j] and s[s[i]+s[j]] in turn
// a permutation load waits for the write port: it is not taken while a data
// byte is in PH_WR_B, only once the engine is idle
// reset clears i/j, the rotation pointer and both valid flags; the
// permutation store is not cleared
// a stalled result holds the engine in its last phase; one request waits
// in the input register meanwhile
module rc4_multi_stream_keystream #(
  parameter int NUM_STREAMS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [rc4ms_pkg::S_TDATA_W-1:0] s_tdata,  // stream[2:0], index[10:3], value[18:11]
  input  logic [rc4ms_pkg::S_TUSER_W-1:0] s_tuser,  // kind[1:0], start_block[2]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rc4ms_pkg::M_TDATA_W-1:0] m_tdata,  // out_byte[7:0]
  output logic [rc4ms_pkg::M_TUSER_W-1:0] m_tuser   // stream_used[2:0]
);
  import rc4ms_pkg::*;

  localparam int SW    = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int AW    = SW + 8;
  localparam int DEPTH = NUM_STREAMS * 256;

  logic          buf_valid;
  req_t          buf_req, req_in;
  logic          req_take;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  // unpack the request
  always_comb begin
    req_in.kind        = kind_t'(s_tuser[1:0]);
    req_in.start_block = s_tuser[2];
    req_in.stream      = s_tdata[2:0];
    req_in.index       = s_tdata[10:3];
    req_in.value       = s_tdata[18:11];
  end

  assign s_tready = !buf_valid || req_take;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      buf_valid <= 1'b1;
    end else if (req_take) begin
      buf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      buf_req <= req_in;
    end
  end

  rc4ms_perm_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rc4ms_engine #(
    .NUM_STREAMS (NUM_STREAMS),
    .SW          (SW),
    .AW          (AW)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (buf_valid),
    .req         (buf_req),
    .req_take    (req_take),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_byte    (m_tdata),
    .stream_used (m_tuser)
  );

endmodule

// File: hdl/rc4ms_perm_mem.sv
// permutation store: one write port, one registered read port
// write data is forwarded to a read of the same address in the same cycle
module rc4ms_perm_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port with write-through forwarding
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

// File: hdl/rc4ms_engine.sv
// keystream engine: sequences reads and writes of the permutation store,
// keeps the per-stream i/j indices, the rotation pointer and the result register
// depends on rc4ms_pkg
module rc4ms_engine #(
  parameter int NUM_STREAMS = 8,
  parameter int SW          = 3,
  parameter int AW          = 11
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  rc4ms_pkg::req_t           req,
  output logic                      req_take,
  output logic                      mem_we,
  output logic [AW-1:0]             mem_waddr,
  output logic [7:0]                mem_wdata,
  output logic                      mem_re,
  output logic [AW-1:0]             mem_raddr,
  input  logic [7:0]                mem_rdata,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_byte,
  output logic [2:0]                stream_used
);
  import rc4ms_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  i_arr [NUM_STREAMS];
  logic [7:0]  j_arr [NUM_STREAMS];
  logic [SW-1:0] rot;
  logic [SW-1:0] cur_s;
  logic [7:0]  a_reg, b_reg, t_reg, j_cur, sa, val_reg;

  logic          out_free, can_start, take_data, ld_ok;
  logic [7:0]    stream_ext, cur_ext;
  logic [SW-1:0] ld_idx, rot_inc, s_new, rot_load;
  logic [7:0]    a_new, b_new, t_new, key;
  logic [4:0]    rv;

  // request decode and index arithmetic
  always_comb begin
    out_free   = !out_valid || out_ready;
    can_start  = (phase == PH_IDLE) ||
                 ((phase == PH_WR_B) && out_free && (req.kind != KIND_PERM));
    req_take   = req_valid && can_start;
    take_data  = req_take && (req.kind == KIND_DATA);
    stream_ext = 8'(req.stream);
    ld_idx     = stream_ext[SW-1:0];
    ld_ok      = int'(req.stream) < NUM_STREAMS;
    rot_inc    = (rot == SW'(NUM_STREAMS - 1)) ? '0 : rot + 1'b1;
    s_new      = req.start_block ? rot_inc : rot;
    a_new      = i_arr[s_new] + 8'd1;
    b_new      = j_cur + mem_rdata;
    t_new      = sa + mem_rdata;
    // s[t] read raced the swap: t == b still holds the old s[b]
    key        = (t_reg == b_reg) ? sa : mem_rdata;
    cur_ext    = 8'(cur_s);
    // pointer load reduced modulo the stream count
    rv = 5'(req.stream);
    for (int k = 0; k < 8; k++) begin
      if (rv >= 5'(NUM_STREAMS)) begin
        rv = rv - 5'(NUM_STREAMS);
      end
    end
    rot_load = rv[SW-1:0];
  end

  // phase sequencing and memory port control
  always_comb begin
    phase_next = phase;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    unique case (phase)
      PH_IDLE: begin
        if (take_data) begin
          phase_next = PH_RD_B;
        end
      end
      PH_RD_B: begin
        mem_re     = 1'b1;
        mem_raddr  = {cur_s, b_new};
        phase_next = PH_RD_T;
      end
      PH_RD_T: begin
        mem_we     = 1'b1;
        mem_waddr  = {cur_s, a_reg};
        mem_wdata  = mem_rdata;
        mem_re     = 1'b1;
        mem_raddr  = {cur_s, t_new};
        phase_next = PH_WR_B;
      end
      PH_WR_B: begin
        mem_we    = 1'b1;
        mem_waddr = {cur_s, b_reg};
        mem_wdata = sa;
        if (out_free) begin
          phase_next = take_data ? PH_RD_B : PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
    // first read of a new step; back to back it overlaps the last write of the previous one
    if (take_data) begin
      mem_re    = 1'b1;
      mem_raddr = {s_new, a_new};
    end
    // permutation load, only taken while the write port is free
    if (req_take && (req.kind == KIND_PERM) && ld_ok) begin
      mem_we    = 1'b1;
      mem_waddr = {ld_idx, req.index};
      mem_wdata = req.value;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      rot       <= '0;
      out_valid <= 1'b0;
      for (int n = 0; n < NUM_STREAMS; n++) begin
        i_arr[n] <= '0;
        j_arr[n] <= '0;
      end
    end else begin
      phase <= phase_next;
      if (req_take && (req.kind == KIND_ROT)) begin
        rot <= rot_load;
      end else if (take_data) begin
        rot <= s_new;
      end
      if (req_take && (req.kind == KIND_IJ) && ld_ok) begin
        i_arr[ld_idx] <= req.index;
        j_arr[ld_idx] <= req.value;
      end
      if (phase == PH_RD_B) begin
        i_arr[cur_s] <= a_reg;
        j_arr[cur_s] <= b_new;
      end
      if ((phase == PH_WR_B) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // step payload and result
  always_ff @(posedge clk) begin
    if (take_data) begin
      cur_s   <= s_new;
      a_reg   <= a_new;
      j_cur   <= j_arr[s_new];
      val_reg <= req.value;
    end
    if (phase == PH_RD_B) begin
      sa    <= mem_rdata;
      b_reg <= b_new;
    end
    if (phase == PH_RD_T) begin
      t_reg <= t_new;
    end
    if ((phase == PH_WR_B) && out_free) begin
      out_byte    <= val_reg ^ key;
      stream_used <= cur_ext[2:0];
    end
  end

endmodule

// File: hdl/rc4ms_checker.sv
// port-level checks for the multi-stream rc4 keystream block, bound to the top
// depends on rc4ms_pkg and assert_macros.svh
`include "assert_macros.svh"

module rc4ms_checker #(
  parameter int NUM_STREAMS = 8
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [rc4ms_pkg::S_TDATA_W-1:0] s_tdata,
  input logic [rc4ms_pkg::S_TUSER_W-1:0] s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [rc4ms_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [rc4ms_pkg::M_TUSER_W-1:0] m_tuser
);

  // reset empties the result register
  `ASSERT_NXT(a_rst_clears_out, clk, 1'b0, rst, !m_tvalid)

  // the input register is empty right after reset
  `ASSERT_NXT(a_ready_after_rst, clk, 1'b0, rst, s_tready)

  // a stalled result holds its value
  `ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
              m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // every result names an existing stream
  `ASSERT_IMP(a_stream_range, clk, rst, m_tvalid, int'(m_tuser) < NUM_STREAMS)

endmodule

bind rc4_multi_stream_keystream rc4ms_checker #(
  .NUM_STREAMS (NUM_STREAMS)
) u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: tb/rc4ms_checker.sv
`timescale 1ns / 100ps
// checker for the multi-stream rc4 keystream block: predicts every result
// from the accepted requests and compares it with what the block returns
// depends on rc4ms_pkg
module rc4ms_tb_checker #(
  parameter int NUM_STREAMS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [rc4ms_pkg::S_TDATA_W-1:0] s_tdata,  // stream[2:0], index[10:3], value[18:11]
  input  logic [rc4ms_pkg::S_TUSER_W-1:0] s_tuser,  // kind[1:0], start_block[2]
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [rc4ms_pkg::M_TDATA_W-1:0] m_tdata,  // out_byte[7:0]
  input  logic [rc4ms_pkg::M_TUSER_W-1:0] m_tuser,  // stream_used[2:0]
  output int                              fail_count,
  output int                              pending
);
  import rc4ms_pkg::*;

  // one predicted result
  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic [STREAM_W-1:0] stream_used;
  } cipher_t;

  // shadow of the generator state
  logic [BYTE_W-1:0]   perm [NUM_STREAMS][256];
  logic [BYTE_W-1:0]   ptr_i [NUM_STREAMS];
  logic [BYTE_W-1:0]   ptr_j [NUM_STREAMS];
  logic [STREAM_W-1:0] rot_ptr;

  cipher_t cipher_q [$];
  int      errs = 0;
  int      n_results = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // one prga step on stream s, returns the keystream byte
  function automatic logic [BYTE_W-1:0] rc4_advance(int s);
    logic [BYTE_W-1:0] a, b, t, tmp;
    a = ptr_i[s] + 8'd1;
    b = ptr_j[s] + perm[s][a];
    ptr_i[s] = a;
    ptr_j[s] = b;
    tmp = perm[s][a];
    perm[s][a] = perm[s][b];
    perm[s][b] = tmp;
    t = perm[s][a] + perm[s][b];
    return perm[s][t];
  endfunction

  function automatic void note_fail(string msg);
    errs++;
    if (errs <= 10) $display("mismatch: %s", msg);
  endfunction

  // follow both channels, predict on requests, compare on results
  always @(posedge clk) begin
    kind_t               k;
    logic [STREAM_W-1:0] strm;
    logic [BYTE_W-1:0]   idx, val, ks;
    logic                sb;
    cipher_t             want;
    if (rst) begin
      for (int n = 0; n < NUM_STREAMS; n++) begin
        ptr_i[n] = '0;
        ptr_j[n] = '0;
      end
      rot_ptr = '0;
      cipher_q.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        k    = kind_t'(s_tuser[1:0]);
        sb   = s_tuser[2];
        strm = s_tdata[2:0];
        idx  = s_tdata[10:3];
        val  = s_tdata[18:11];
        case (k)
          KIND_PERM: begin
            if (int'(strm) < NUM_STREAMS) perm[strm][idx] = val;
          end
          KIND_IJ: begin
            if (int'(strm) < NUM_STREAMS) begin
              ptr_i[strm] = idx;
              ptr_j[strm] = val;
            end
          end
          KIND_ROT: begin
            rot_ptr = STREAM_W'(int'(strm) % NUM_STREAMS);
          end
          KIND_DATA: begin
            if (sb) rot_ptr = STREAM_W'((int'(rot_ptr) + 1) % NUM_STREAMS);
            ks = rc4_advance(int'(rot_ptr));
            cipher_q.push_back('{out_byte: val ^ ks, stream_used: rot_ptr});
          end
        endcase
      end
      if (m_tvalid && m_tready) begin
        n_results++;
        if (cipher_q.size() == 0) begin
          note_fail($sformatf("result %0d: byte %02h stream %0d with nothing expected",
                              n_results, m_tdata, m_tuser));
        end else begin
          want = cipher_q.pop_front();
          if (m_tdata !== want.out_byte || m_tuser !== want.stream_used)
            note_fail($sformatf("result %0d: expected byte %02h stream %0d, got byte %02h stream %0d",
                                n_results, want.out_byte, want.stream_used, m_tdata, m_tuser));
        end
      end
    end
    fail_count <= errs;
    pending    <= cipher_q.size();
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// stimulus and verdict for the multi-stream rc4 keystream block
// depends on rc4ms_pkg, rc4_multi_stream_keystream and rc4ms_tb_checker
module tb_top;
  import rc4ms_pkg::*;

  localparam int NUM_STREAMS = 8;
  localparam int QUIET_LIMIT = 5000;
  // streams whose permutations are fully loaded; keystream steps stay on them
  localparam int FILLED = 2;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;  // stream[2:0], index[10:3], value[18:11]
  logic [S_TUSER_W-1:0] s_tuser = '0;  // kind[1:0], start_block[2]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;       // out_byte[7:0]
  logic [M_TUSER_W-1:0] m_tuser;       // stream_used[2:0]

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet = 0;
  int rot_sh = 0;

  rc4_multi_stream_keystream #(.NUM_STREAMS(NUM_STREAMS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  rc4ms_tb_checker #(.NUM_STREAMS(NUM_STREAMS)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("rc4_multi_stream_keystream regression: fail");
      $finish;
    end
  end

  // present one request, with random gaps ahead of it, and wait for acceptance
  task automatic send_req(kind_t k, logic [2:0] strm, logic [7:0] idx, logic [7:0] val,
                          logic sb);
    // track the rotation pointer so keystream steps stay on loaded streams
    if (k == KIND_ROT) rot_sh = int'(strm) % NUM_STREAMS;
    else if (k == KIND_DATA && sb) rot_sh = (rot_sh + 1) % NUM_STREAMS;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, val, idx, strm};
    s_tuser  <= {sb, k};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // data byte whose start flag keeps the pointer on a loaded stream
  task automatic send_data(logic [7:0] val);
    logic cur_ok, nxt_ok, sb;
    cur_ok = rot_sh < FILLED;
    nxt_ok = ((rot_sh + 1) % NUM_STREAMS) < FILLED;
    sb = (cur_ok && nxt_ok) ? ($urandom_range(3) == 0) : nxt_ok;
    send_req(KIND_DATA, 3'($urandom), 8'($urandom), val, sb);
  endtask

  // every entry of the loaded streams gets written before any keystream step
  task automatic fill_permutations();
    for (int s = 0; s < FILLED; s++)
      for (int n = 0; n < 256; n++)
        send_req(KIND_PERM, 3'(s), 8'(n), 8'($urandom), 1'($urandom));
  endtask

  // edge cases: byte extremes, i wrap, pointer wrap, ignored start flags
  task automatic directed_requests();
    send_req(KIND_DATA, 3'd0, 8'd0, 8'h00, 1'b0);
    send_req(KIND_DATA, 3'd7, 8'hff, 8'hff, 1'b1);
    send_req(KIND_IJ, 3'd1, 8'hff, 8'hff, 1'b1);
    send_req(KIND_DATA, 3'd0, 8'd0, 8'ha5, 1'b0);
    send_req(KIND_ROT, 3'd7, 8'hff, 8'h00, 1'b0);
    send_req(KIND_DATA, 3'd0, 8'd0, 8'h5a, 1'b1);
    send_req(KIND_PERM, 3'd0, 8'hff, 8'hff, 1'b0);
    send_req(KIND_PERM, 3'd0, 8'h00, 8'h00, 1'b1);
    send_req(KIND_IJ, 3'd0, 8'hfe, 8'h00, 1'b0);
    send_req(KIND_DATA, 3'd0, 8'd0, 8'hff, 1'b0);
    send_req(KIND_DATA, 3'd0, 8'd0, 8'h00, 1'b0);
    send_req(KIND_ROT, 3'd6, 8'h00, 8'hff, 1'b1);
    send_req(KIND_ROT, 3'd7, 8'h00, 8'hff, 1'b1);
    send_req(KIND_DATA, 3'd0, 8'd0, 8'h3c, 1'b1);
    send_req(KIND_DATA, 3'd0, 8'd0, 8'hc3, 1'b1);
    send_req(KIND_DATA, 3'd0, 8'd0, 8'h81, 1'b0);
    send_req(KIND_IJ, 3'd7, 8'h00, 8'h00, 1'b0);
    send_req(KIND_ROT, 3'd0, 8'h00, 8'h00, 1'b0);
    send_req(KIND_DATA, 3'd0, 8'd0, 8'h7e, 1'b0);
    // walk the pointer over the loaded streams, wrapping from the top
    send_req(KIND_ROT, 3'(NUM_STREAMS - 1), 8'h00, 8'h00, 1'b0);
    for (int s = 0; s < FILLED; s++)
      send_req(KIND_DATA, 3'd0, 8'd0, 8'($urandom), 1'b1);
  endtask

  // mostly keystream bytes, mixed with reloads of state
  task automatic random_requests(int count);
    int roll;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 55)
        send_data(8'($urandom));
      else if (roll < 75)
        send_req(KIND_PERM, 3'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      else if (roll < 90)
        send_req(KIND_IJ, 3'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      else
        send_req(KIND_ROT, 3'($urandom_range(FILLED) + NUM_STREAMS - 1), 8'($urandom),
                 8'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // sender idles lightly, receiver heavily
    send_idle_pct = 24;
    recv_idle_pct = 88;
    fill_permutations();
    directed_requests();
    random_requests(110);

    // roles swapped
    send_idle_pct = 88;
    recv_idle_pct = 24;
    random_requests(110);

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_requests(100);
    s_tvalid <= 1'b0;

    // drain outstanding results, then let the pipeline settle
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("rc4_multi_stream_keystream regression: pass");
    else
      $display("rc4_multi_stream_keystream regression: fail");
    $finish;
  end

endmodule
